/* design/boolean_cover_gain_select_defines.svh */
// assertion macros for the boolean cover gain selector
// no dependencies; included by the top level only
`ifndef BOOLEAN_COVER_GAIN_SELECT_DEFINES_SVH
`define BOOLEAN_COVER_GAIN_SELECT_DEFINES_SVH
`ifndef ASSERT_OFF
// property must hold at every clock edge outside reset
`define BCGS_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("bcgs assertion failed");
// condition must never be true outside reset
`define BCGS_ASSERT_NEVER(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("bcgs forbidden condition seen");
`else
`define BCGS_ASSERT(lbl, clk, rst_n, prop)
`define BCGS_ASSERT_NEVER(lbl, clk, rst_n, cond)
`endif
`endif

/* design/bcgs_pkg.sv */
// shared types and constants of the boolean cover gain selector
// no dependencies; used by every module of the block
package bcgs_pkg;

    localparam int ROWS_DEF           = 64;
    localparam int COLUMNS_DEF        = 64;
    localparam int MAX_CANDIDATES_DEF = 1024;

    localparam int DATA_W    = 64;
    localparam int POS_W     = 10;
    localparam int GAIN_W    = 13;
    localparam int COL_W     = 6;
    localparam int CAND_CMP_W = 17;

    // row lanes
    localparam int LANES      = 4;
    localparam int LANE_ROWS  = DATA_W / LANES;
    localparam int LANE_CNT_W = $clog2(LANE_ROWS + 1);
    localparam int SUM_W      = $clog2(DATA_W + 1);

    typedef struct packed {
        logic [DATA_W-1:0] data_column;
        logic [DATA_W-1:0] mask_column;
        logic [DATA_W-1:0] candidate_column;
        logic              last_column;
        logic              last_candidate;
    } t_in_word;

    typedef struct packed {
        logic [POS_W-1:0]  best_position;
        logic [GAIN_W-1:0] best_gain;
        logic [DATA_W-1:0] usage_row;
    } t_out_word;

    typedef struct packed {
        logic last_column;
        logic last_candidate;
    } t_flags;

    typedef struct packed {
        logic [LANE_CNT_W-1:0] hit;
        logic [LANE_CNT_W-1:0] miss;
    } t_lane_cnt;

    typedef struct packed {
        logic             positive;
        logic [SUM_W-1:0] diff;
        t_flags           flags;
    } t_score;

endpackage

/* design/bcgs_lane.sv */
// one row lane: hit and miss counts over a slice of the column
// depends on bcgs_pkg
module bcgs_lane (
    input  logic                               i_clk,
    input  logic                               i_en,
    input  logic [bcgs_pkg::LANE_ROWS-1:0]     i_data,
    input  logic [bcgs_pkg::LANE_ROWS-1:0]     i_open,
    input  logic [bcgs_pkg::LANE_ROWS-1:0]     i_cand,
    output bcgs_pkg::t_lane_cnt                o_cnt
);

    bcgs_pkg::t_lane_cnt n_cnt;
    bcgs_pkg::t_lane_cnt r_cnt;

    // count open candidate rows that match or contradict the data
    always_comb begin
        n_cnt = '0;
        for (int r = 0; r < bcgs_pkg::LANE_ROWS; r++) begin
            n_cnt.hit  = n_cnt.hit
                + bcgs_pkg::LANE_CNT_W'(i_cand[r] & i_data[r] & i_open[r]);
            n_cnt.miss = n_cnt.miss
                + bcgs_pkg::LANE_CNT_W'(i_cand[r] & ~i_data[r] & i_open[r]);
        end
    end

    // lane result register
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_cnt <= n_cnt;
        end
    end

    assign o_cnt = r_cnt;

endmodule

/* design/bcgs_merge.sv */
// merges lane counts into one column score
// depends on bcgs_pkg
module bcgs_merge (
    input  logic                i_clk,
    input  logic                i_en,
    input  bcgs_pkg::t_lane_cnt i_cnt [bcgs_pkg::LANES],
    input  bcgs_pkg::t_flags    i_flags,
    output bcgs_pkg::t_score    o_score
);

    logic [bcgs_pkg::SUM_W-1:0] hit_sum;
    logic [bcgs_pkg::SUM_W-1:0] miss_sum;
    bcgs_pkg::t_score           n_score;
    bcgs_pkg::t_score           r_score;

    // sum lanes
    always_comb begin
        hit_sum  = '0;
        miss_sum = '0;
        for (int l = 0; l < bcgs_pkg::LANES; l++) begin
            hit_sum  = hit_sum + bcgs_pkg::SUM_W'(i_cnt[l].hit);
            miss_sum = miss_sum + bcgs_pkg::SUM_W'(i_cnt[l].miss);
        end
    end

    // score is only used when positive
    always_comb begin
        n_score.positive = hit_sum > miss_sum;
        n_score.diff     = hit_sum - miss_sum;
        n_score.flags    = i_flags;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_score <= n_score;
        end
    end

    assign o_score = r_score;

endmodule

/* design/bcgs_accum.sv */
// gain and usage accumulation per candidate, best candidate tracking
// depends on bcgs_pkg
module bcgs_accum #(
    parameter int ROWS           = bcgs_pkg::ROWS_DEF,
    parameter int COLUMNS        = bcgs_pkg::COLUMNS_DEF,
    parameter int MAX_CANDIDATES = bcgs_pkg::MAX_CANDIDATES_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  bcgs_pkg::t_score    i_score,
    output bcgs_pkg::t_out_word o_result
);

    localparam logic [bcgs_pkg::GAIN_W-1:0]     GainCap  =
        bcgs_pkg::GAIN_W'(ROWS * COLUMNS);
    localparam logic [bcgs_pkg::COL_W:0]        ColLimit =
        (bcgs_pkg::COL_W + 1)'(COLUMNS);
    localparam logic [bcgs_pkg::CAND_CMP_W-1:0] CandLimit =
        bcgs_pkg::CAND_CMP_W'(MAX_CANDIDATES);

    logic [bcgs_pkg::COL_W-1:0]  r_col;
    logic [bcgs_pkg::POS_W-1:0]  r_cand;
    logic [bcgs_pkg::GAIN_W-1:0] r_gain;
    logic [bcgs_pkg::DATA_W-1:0] r_usage;
    logic [bcgs_pkg::GAIN_W-1:0] r_best_gain;
    logic [bcgs_pkg::DATA_W-1:0] r_best_usage;
    logic [bcgs_pkg::POS_W-1:0]  r_best_pos;
    logic                        r_have;

    logic [bcgs_pkg::GAIN_W-1:0] sum_gain;
    logic [bcgs_pkg::GAIN_W-1:0] n_gain;
    logic [bcgs_pkg::DATA_W-1:0] n_usage;
    logic [bcgs_pkg::COL_W:0]    col_inc;
    logic [bcgs_pkg::COL_W-1:0]  n_col;
    logic [bcgs_pkg::CAND_CMP_W-1:0] cand_inc;
    logic [bcgs_pkg::POS_W-1:0]  n_cand;
    logic                        take;

    // saturating gain update and usage bit for this column
    always_comb begin
        sum_gain = r_gain + bcgs_pkg::GAIN_W'(i_score.diff);
        n_gain   = r_gain;
        n_usage  = r_usage;
        if (i_score.positive) begin
            n_gain  = (sum_gain > GainCap) ? GainCap : sum_gain;
            n_usage = r_usage | (bcgs_pkg::DATA_W'(1) << r_col);
        end
    end

    // column and candidate counters with wrap
    always_comb begin
        col_inc  = {1'b0, r_col} + 1'b1;
        n_col    = (col_inc >= ColLimit) ? '0 : col_inc[bcgs_pkg::COL_W-1:0];
        cand_inc = bcgs_pkg::CAND_CMP_W'(r_cand) + 1'b1;
        n_cand   = (cand_inc >= CandLimit) ? '0 : cand_inc[bcgs_pkg::POS_W-1:0];
    end

    // first candidate, or a strictly better one, replaces the best
    assign take = i_score.flags.last_column && (!r_have || n_gain > r_best_gain);

    // best after this word, loaded by the top level when a sweep ends
    always_comb begin
        o_result.best_position = take ? r_cand  : r_best_pos;
        o_result.best_gain     = take ? n_gain  : r_best_gain;
        o_result.usage_row     = take ? n_usage : r_best_usage;
    end

    // sweep state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col        <= '0;
            r_cand       <= '0;
            r_gain       <= '0;
            r_usage      <= '0;
            r_best_gain  <= '0;
            r_best_usage <= '0;
            r_best_pos   <= '0;
            r_have       <= 1'b0;
        end else if (i_en) begin
            if (!i_score.flags.last_column) begin
                r_col   <= n_col;
                r_gain  <= n_gain;
                r_usage <= n_usage;
            end else begin
                r_col   <= '0;
                r_gain  <= '0;
                r_usage <= '0;
                if (!i_score.flags.last_candidate) begin
                    r_cand <= n_cand;
                    if (take) begin
                        r_have       <= 1'b1;
                        r_best_gain  <= n_gain;
                        r_best_usage <= n_usage;
                        r_best_pos   <= r_cand;
                    end
                end else begin
                    r_cand       <= '0;
                    r_have       <= 1'b0;
                    r_best_gain  <= '0;
                    r_best_usage <= '0;
                    r_best_pos   <= '0;
                end
            end
        end
    end

endmodule

/* design/boolean_cover_gain_select.sv */
// Boolean cover gain selector. Each input word carries one data column, its
// covered mask and the current candidate column; the block scores the column,
// accumulates the candidate's gain and usage row, keeps the first strictly
// best candidate and, after the last column of the last candidate, emits one
// output word with best position, gain and usage row. Throughput is one word
// per clock: the rows are split over four lanes that count hits and misses in
// parallel (stage 1), a merge stage adds the lane counts into one score
// (stage 2), and the gain/best update closes the only loop. A
// result passes the lane and merge registers before it is loaded into the
// output register. Words that produce no result keep flowing while an output
// word waits; only a sweep end behind a waiting output word holds the pipe.
// depends on bcgs_pkg, bcgs_lane, bcgs_merge, bcgs_accum and the defines header
`include "boolean_cover_gain_select_defines.svh"

module boolean_cover_gain_select #(
    parameter int ROWS           = bcgs_pkg::ROWS_DEF,
    parameter int COLUMNS        = bcgs_pkg::COLUMNS_DEF,
    parameter int MAX_CANDIDATES = bcgs_pkg::MAX_CANDIDATES_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  bcgs_pkg::t_in_word  i_word,
    output logic                o_valid,
    input  logic                i_stall,
    output bcgs_pkg::t_out_word o_word
);

    localparam logic [bcgs_pkg::GAIN_W-1:0] GainCap =
        bcgs_pkg::GAIN_W'(ROWS * COLUMNS);

    logic [bcgs_pkg::DATA_W-1:0] row_mask;
    logic [bcgs_pkg::DATA_W-1:0] data_m;
    logic [bcgs_pkg::DATA_W-1:0] open_m;
    logic [bcgs_pkg::DATA_W-1:0] cand_m;

    logic                 r_v1;
    logic                 r_v2;
    bcgs_pkg::t_flags     r_flags1;
    bcgs_pkg::t_flags     in_flags;
    bcgs_pkg::t_lane_cnt  lane_cnt [bcgs_pkg::LANES];
    bcgs_pkg::t_score     score;
    bcgs_pkg::t_out_word  result;
    bcgs_pkg::t_out_word  r_out;
    logic                 r_out_valid;

    logic emit;
    logic consume;
    logic adv1;
    logic adv2;
    logic load;

    // rows beyond ROWS are ignored in all three columns
    always_comb begin
        for (int r = 0; r < bcgs_pkg::DATA_W; r++) begin
            row_mask[r] = (r < ROWS);
        end
        data_m = i_word.data_column & row_mask;
        open_m = ~i_word.mask_column & row_mask;
        cand_m = i_word.candidate_column & row_mask;
    end

    assign in_flags.last_column    = i_word.last_column;
    assign in_flags.last_candidate = i_word.last_candidate;

    // pipe flow: only a sweep end waits for the output register
    assign emit    = score.flags.last_column && score.flags.last_candidate;
    assign consume = r_v2 && !(emit && r_out_valid && i_stall);
    assign adv2    = !r_v2 || consume;
    assign adv1    = !r_v1 || adv2;
    assign load    = consume && emit;
    assign o_stall = !adv1;

    // row lanes
    for (genvar l = 0; l < bcgs_pkg::LANES; l++) begin : g_lane
        bcgs_lane u_lane (
            .i_clk  (i_clk),
            .i_en   (adv1),
            .i_data (data_m[l*bcgs_pkg::LANE_ROWS +: bcgs_pkg::LANE_ROWS]),
            .i_open (open_m[l*bcgs_pkg::LANE_ROWS +: bcgs_pkg::LANE_ROWS]),
            .i_cand (cand_m[l*bcgs_pkg::LANE_ROWS +: bcgs_pkg::LANE_ROWS]),
            .o_cnt  (lane_cnt[l])
        );
    end

    // merge lane counts
    bcgs_merge u_merge (
        .i_clk   (i_clk),
        .i_en    (adv2),
        .i_cnt   (lane_cnt),
        .i_flags (r_flags1),
        .o_score (score)
    );

    // accumulate and select
    bcgs_accum #(
        .ROWS           (ROWS),
        .COLUMNS        (COLUMNS),
        .MAX_CANDIDATES (MAX_CANDIDATES)
    ) u_accum (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (consume),
        .i_score  (score),
        .o_result (result)
    );

    // stage valids and flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (adv1) begin
                r_v1 <= i_valid;
            end
            if (adv2) begin
                r_v2 <= r_v1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv1) begin
            r_flags1 <= in_flags;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out <= result;
        end
    end

    assign o_valid = r_out_valid;
    assign o_word  = r_out;

    // checks
    `BCGS_ASSERT(a_out_from_sweep_end, i_clk, i_rst_n, $rose(r_out_valid) |-> $past(load))
    `BCGS_ASSERT(a_stage2_held, i_clk, i_rst_n, (r_v2 && !consume) |=> (r_v2 && $stable(score)))
    `BCGS_ASSERT_NEVER(a_gain_cap, i_clk, i_rst_n, r_out_valid && (r_out.best_gain > GainCap))

endmodule

/* tb/tb_top.sv */
// self-checking bench for the boolean cover gain selector: streams column words,
// predicts each sweep's best candidate and compares every output word against it
// depends on bcgs_pkg and the boolean_cover_gain_select top level
module tb_top;

    localparam int DATA_W             = bcgs_pkg::DATA_W;
    localparam int COL_W              = bcgs_pkg::COL_W;
    localparam int POS_W              = bcgs_pkg::POS_W;
    localparam int GAIN_W             = bcgs_pkg::GAIN_W;
    localparam int ROWS_DEF           = bcgs_pkg::ROWS_DEF;
    localparam int COLUMNS_DEF        = bcgs_pkg::COLUMNS_DEF;
    localparam int MAX_CANDIDATES_DEF = bcgs_pkg::MAX_CANDIDATES_DEF;

    typedef bcgs_pkg::t_in_word  t_in_word;
    typedef bcgs_pkg::t_out_word t_out_word;

    localparam int GAIN_CAP     = ROWS_DEF * COLUMNS_DEF;
    localparam int IDLE_LIMIT   = 2000;
    localparam int TARGET_WORDS = 1450;
    localparam int REPORT_LIMIT = 10;
    localparam int WRAP_SWEEP   = MAX_CANDIDATES_DEF + 4;
    localparam logic [DATA_W-1:0] ALL_ONES = {DATA_W{1'b1}};

    logic      i_clk   = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_valid = 1'b0;
    t_in_word  i_word  = '0;
    logic      i_stall = 1'b0;
    logic      o_stall;
    logic      o_valid;
    t_out_word o_word;

    // sweep state of the predictor
    logic [COL_W-1:0]  col_idx       = '0;
    logic [POS_W-1:0]  cand_idx      = '0;
    int unsigned       run_gain      = 0;
    logic [DATA_W-1:0] run_usage     = '0;
    int unsigned       best_gain_hold = 0;
    logic [DATA_W-1:0] best_usage_hold = '0;
    logic [POS_W-1:0]  best_pos_hold = '0;
    logic              have_best     = 1'b0;

    t_out_word best_cover_q[$];

    // bench bookkeeping
    bit          gaps_on   = 1'b1;
    bit          stalls_on = 1'b1;
    int unsigned words_sent      = 0;
    int unsigned sweeps_closed   = 0;
    int unsigned results_checked = 0;
    int unsigned mismatches      = 0;
    int unsigned stall_left      = 0;
    int unsigned idle_cycles     = 0;

    boolean_cover_gain_select u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_word  (i_word),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_word  (o_word)
    );

    // clock, period 10
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic int unsigned count_rows(logic [DATA_W-1:0] v);
        int unsigned n = 0;
        for (int r = 0; r < DATA_W; r++) n += v[r];
        return n;
    endfunction

    function automatic logic [DATA_W-1:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic t_in_word make_word(logic [DATA_W-1:0] data, logic [DATA_W-1:0] mask,
                                           logic [DATA_W-1:0] cand, logic lc, logic lk);
        t_in_word w;
        w.data_column      = data;
        w.mask_column      = mask;
        w.candidate_column = cand;
        w.last_column      = lc;
        w.last_candidate   = lk;
        return w;
    endfunction

    // score one accepted column word and close candidate / sweep when flagged
    task automatic update_cover_gain(input t_in_word w);
        int unsigned hit;
        int unsigned miss;
        int unsigned sum;
        t_out_word   best;
        hit  = count_rows(w.candidate_column & w.data_column & ~w.mask_column);
        miss = count_rows(w.candidate_column & ~w.data_column & ~w.mask_column);
        if (hit > miss) begin
            sum = run_gain + hit - miss;
            run_gain = (sum > GAIN_CAP) ? GAIN_CAP : sum;
            run_usage[col_idx] = 1'b1;
        end
        if (!w.last_column) begin
            col_idx++;
        end else begin
            // first candidate always kept, later ones only when strictly better
            if (!have_best || run_gain > best_gain_hold) begin
                have_best       = 1'b1;
                best_gain_hold  = run_gain;
                best_usage_hold = run_usage;
                best_pos_hold   = cand_idx;
            end
            col_idx   = '0;
            run_gain  = 0;
            run_usage = '0;
            if (!w.last_candidate) begin
                cand_idx++;
            end else begin
                best.best_position = best_pos_hold;
                best.best_gain     = GAIN_W'(best_gain_hold);
                best.usage_row     = best_usage_hold;
                best_cover_q.push_back(best);
                sweeps_closed++;
                cand_idx        = '0;
                have_best       = 1'b0;
                best_gain_hold  = 0;
                best_usage_hold = '0;
                best_pos_hold   = '0;
            end
        end
    endtask

    // drive one column word after a random gap and wait for it to be taken
    task automatic send_word(input t_in_word w);
        int unsigned gap;
        gap = gaps_on ? $urandom_range(0, 9) : 0;
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_word  <= w;
        do @(posedge i_clk); while (o_stall);
        update_cover_gain(w);
        words_sent++;
    endtask

    // hold off the sender until every pending output word has arrived
    task automatic wait_drained();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (best_cover_q.size() != 0);
    endtask

    // compare one output word with the oldest prediction
    task automatic check_result(input t_out_word got);
        t_out_word want;
        if (best_cover_q.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
                $display("unexpected output word: pos %0d gain %0d usage %h",
                         got.best_position, got.best_gain, got.usage_row);
        end else begin
            want = best_cover_q.pop_front();
            results_checked++;
            if (got.best_position !== want.best_position || got.best_gain !== want.best_gain
                    || got.usage_row !== want.usage_row) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display({"mismatch: expected pos %0d gain %0d usage %h, ",
                              "got pos %0d gain %0d usage %h"},
                             want.best_position, want.best_gain, want.usage_row,
                             got.best_position, got.best_gain, got.usage_row);
            end
        end
    endtask

    // output side: take words, stall at random in any phase
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
            stall_left = 0;
        end else begin
            if (o_valid && !i_stall) begin
                check_result(o_word);
                stall_left = stalls_on ? $urandom_range(0, 9) : 0;
            end else if (stall_left != 0) begin
                stall_left--;
            end else if (!o_valid && stalls_on && $urandom_range(0, 7) == 0) begin
                stall_left = $urandom_range(1, 9);
            end
            i_stall <= (stall_left != 0);
        end
    end

    // watchdog on cycles with no word moving on either side
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // full hit, full miss, masked and empty columns; last_candidate ignored mid-candidate
    task automatic test_field_extremes();
        gaps_on   = 1'b1;
        stalls_on = 1'b1;
        send_word(make_word(ALL_ONES, '0, ALL_ONES, 1'b0, 1'b0));
        send_word(make_word('0, '0, ALL_ONES, 1'b0, 1'b1));
        send_word(make_word(ALL_ONES, ALL_ONES, ALL_ONES, 1'b0, 1'b0));
        send_word(make_word(ALL_ONES, ALL_ONES, '0, 1'b1, 1'b1));
        wait_drained();
    endtask

    // first candidate kept at zero gain, ties keep the earlier, hit equal to miss scores nothing
    task automatic test_best_selection();
        gaps_on   = 1'b0;
        stalls_on = 1'b0;
        send_word(make_word('0, '0, ALL_ONES, 1'b1, 1'b0));
        send_word(make_word(ALL_ONES, '0, 64'h3ff, 1'b1, 1'b0));
        send_word(make_word(ALL_ONES, '0, 64'h3ff << 20, 1'b1, 1'b0));
        send_word(make_word(64'h0f, '0, 64'hff, 1'b1, 1'b1));
        send_word(make_word('0, ALL_ONES, ALL_ONES, 1'b1, 1'b0));
        send_word(make_word(64'h0f, '0, 64'hff, 1'b1, 1'b1));
    endtask

    // more columns than the usage row holds: gain saturates, usage bits wrap
    task automatic test_gain_saturation();
        gaps_on   = 1'b1;
        stalls_on = 1'b1;
        for (int k = 0; k < COLUMNS_DEF + 2; k++)
            send_word(make_word(ALL_ONES, '0, ALL_ONES, k == COLUMNS_DEF + 1, 1'b0));
        send_word(make_word(rand64(), rand64(), rand64(), 1'b1, 1'b1));
    endtask

    // sweep longer than the position counter: best sits past the wrap
    task automatic test_candidate_wrap();
        logic [DATA_W-1:0] cand;
        stalls_on = 1'b1;
        for (int c = 0; c < WRAP_SWEEP; c++) begin
            gaps_on = ((c / 128) % 2) == 0;
            if (c == MAX_CANDIDATES_DEF + 1) begin
                send_word(make_word(ALL_ONES, '0, ALL_ONES, 1'b1, 1'b0));
            end else begin
                cand = rand64() & rand64() & rand64() & rand64();
                send_word(make_word(rand64(), rand64() & rand64(), cand, 1'b1,
                                    c == WRAP_SWEEP - 1));
            end
        end
    endtask

    // one well-formed sweep with random content
    task automatic send_sweep(input int unsigned n_cands, input int unsigned max_cols);
        logic [DATA_W-1:0] cand;
        logic [DATA_W-1:0] data;
        logic [DATA_W-1:0] mask;
        int unsigned       n_cols;
        logic              lk;
        for (int c = 0; c < n_cands; c++) begin
            case ($urandom_range(0, 3))
                0: cand = rand64();
                1: cand = rand64() & rand64();
                2: cand = rand64() | rand64();
                default: cand = ($urandom_range(0, 1) == 0) ? ALL_ONES
                                                            : rand64() & rand64() & rand64();
            endcase
            n_cols = $urandom_range(1, max_cols);
            for (int k = 0; k < n_cols; k++) begin
                case ($urandom_range(0, 3))
                    0: data = rand64();
                    1: data = cand | rand64();
                    2: data = cand & rand64();
                    default: data = ~cand | rand64();
                endcase
                case ($urandom_range(0, 5))
                    0, 1: mask = '0;
                    2:    mask = rand64();
                    3:    mask = ALL_ONES;
                    default: mask = rand64() & rand64();
                endcase
                if (k == n_cols - 1) lk = (c == n_cands - 1);
                else lk = ($urandom_range(0, 3) == 0);
                send_word(make_word(data, mask, cand, k == n_cols - 1, lk));
            end
        end
    endtask

    // random sweeps with some stray words and occasional drain pauses
    task automatic test_random_sweeps();
        while (words_sent < TARGET_WORDS) begin
            gaps_on   = ($urandom_range(0, 3) != 0);
            stalls_on = ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 9) == 0)
                send_word(make_word(rand64(), rand64(), rand64(),
                                    1'($urandom_range(0, 1)), 1'($urandom_range(0, 1))));
            else
                send_sweep($urandom_range(1, 4), $urandom_range(1, 4));
            if ($urandom_range(0, 5) == 0) wait_drained();
        end
    endtask

    // test sequence
    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_field_extremes();
        test_best_selection();
        test_gain_saturation();
        test_candidate_wrap();
        test_random_sweeps();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (best_cover_q.size() != 0);
        repeat (8) @(posedge i_clk);
        $display("run covered %0d column words over %0d sweeps, %0d output words checked",
                 words_sent, sweeps_closed, results_checked);
        $display("including gain saturation, usage wrap and a sweep past the position wrap");
        if (mismatches == 0 && best_cover_q.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
